// ===== rtl/rpse_pkg.sv =====
`timescale 1ns / 1ps

package rpse_pkg;

    localparam int NUM_TERMS = 36;
    localparam int COEF_W    = 48;
    localparam int MONO_W    = 32;
    localparam int LO_W      = 56;
    localparam int HI_W      = 57;
    localparam int PROD_W    = 81;
    localparam int SUM_W     = 88;
    localparam int GROUPS    = 6;
    localparam int GROUP_N   = 6;
    localparam int FRAC_DROP = 24;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [MONO_W-1:0]        mono_t;
    typedef logic [LO_W-1:0]          lo_t;
    typedef logic signed [HI_W-1:0]   hi_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

endpackage

// ===== rtl/rgb_polynomial_spectrum_eval.sv =====
`timescale 1ns / 1ps

// channel   | ports                                          | dir
// input     | s_valid s_ready s_cmd s_red s_green s_blue      | in
//           | s_band s_term s_coefficient                      |
// result    | m_valid m_ready m_out_band m_spectral_value      | out
//           | m_saturated                                      |
//
// One transfer per cycle in, one per cycle out. Coefficient writes take effect
// for any later evaluate. The whole pipeline holds while a result waits on
// m_ready. Synchronous active-low reset clears valid bits only; coefficient
// RAM is undefined until written.
module rgb_polynomial_spectrum_eval
    import rpse_pkg::*;
#(
    parameter int NUM_BANDS = 512
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  logic [7:0]          s_red,
    input  logic [7:0]          s_green,
    input  logic [7:0]          s_blue,
    input  logic [8:0]          s_band,
    input  logic [5:0]          s_term,
    input  logic signed [47:0]  s_coefficient,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [8:0]          m_out_band,
    output logic signed [31:0]  m_spectral_value,
    output logic                m_saturated
);

    localparam int DEPTH = (NUM_BANDS > 512) ? 512 : NUM_BANDS;
    localparam int AW    = (DEPTH < 2) ? 1 : $clog2(DEPTH);

    coef_t mem [DEPTH-1:0][NUM_TERMS-1:0];

    logic adv;
    logic band_ok;
    logic [AW-1:0] addr;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign band_ok = 32'(s_band) < NUM_BANDS;
    assign addr    = AW'(s_band);

    // stage 1: RAM row read
    coef_t row1_reg [NUM_TERMS-1:0];
    logic [7:0] r1_reg, g1_reg, b1_reg;
    logic [8:0] band1_reg;
    logic v1_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && adv && band_ok && s_cmd == CMD_WRITE && 32'(s_term) < NUM_TERMS) begin
            mem[addr][s_term] <= s_coefficient;
        end
        if (adv) begin
            row1_reg  <= mem[addr];
            r1_reg    <= s_red;
            g1_reg    <= s_green;
            b1_reg    <= s_blue;
            band1_reg <= s_band;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid && band_ok && s_cmd == CMD_EVAL;
        end
    end

    // stage 2: degree 0..2
    mono_t t2_next [NUM_TERMS-1:0];
    mono_t t2_reg  [NUM_TERMS-1:0];
    coef_t row2_reg [NUM_TERMS-1:0];
    logic [8:0] band2_reg;
    logic [7:0] r2_reg, g2_reg, b2_reg;
    logic v2_reg;

    always_comb begin
        mono_t r, g, b;
        r = MONO_W'(r1_reg);
        g = MONO_W'(g1_reg);
        b = MONO_W'(b1_reg);
        for (int k = 0; k < NUM_TERMS; k++) begin
            t2_next[k] = '0;
        end
        t2_next[0]  = MONO_W'(1);
        t2_next[1]  = MONO_W'(1);
        t2_next[2]  = r;
        t2_next[3]  = g;
        t2_next[4]  = b;
        t2_next[5]  = r * r;
        t2_next[6]  = r * g;
        t2_next[7]  = r * b;
        t2_next[8]  = g * g;
        t2_next[9]  = g * b;
        t2_next[10] = b * b;
    end

    // stage 3: degree 3
    mono_t t3_next [NUM_TERMS-1:0];
    mono_t t3_reg  [NUM_TERMS-1:0];
    coef_t row3_reg [NUM_TERMS-1:0];
    logic [8:0] band3_reg;
    logic [7:0] r3_reg, g3_reg, b3_reg;
    logic v3_reg;

    always_comb begin
        mono_t r, g, b;
        r = MONO_W'(r2_reg);
        g = MONO_W'(g2_reg);
        b = MONO_W'(b2_reg);
        t3_next = t2_reg;
        t3_next[11] = t2_reg[5] * r;
        t3_next[12] = t2_reg[5] * g;
        t3_next[13] = t2_reg[5] * b;
        t3_next[14] = t2_reg[6] * g;
        t3_next[15] = t2_reg[6] * b;
        t3_next[16] = t2_reg[7] * b;
        t3_next[17] = t2_reg[8] * g;
        t3_next[18] = t2_reg[8] * b;
        t3_next[19] = t2_reg[9] * b;
        t3_next[20] = t2_reg[10] * b;
    end

    // stage 4: degree 4
    mono_t t4_next [NUM_TERMS-1:0];
    mono_t t4_reg  [NUM_TERMS-1:0];
    coef_t row4_reg [NUM_TERMS-1:0];
    logic [8:0] band4_reg;
    logic v4_reg;

    always_comb begin
        mono_t r, g, b;
        r = MONO_W'(r3_reg);
        g = MONO_W'(g3_reg);
        b = MONO_W'(b3_reg);
        t4_next = t3_reg;
        t4_next[21] = t3_reg[11] * r;
        t4_next[22] = t3_reg[11] * g;
        t4_next[23] = t3_reg[11] * b;
        t4_next[24] = t3_reg[12] * g;
        t4_next[25] = t3_reg[12] * b;
        t4_next[26] = t3_reg[13] * b;
        t4_next[27] = t3_reg[14] * g;
        t4_next[28] = t3_reg[14] * b;
        t4_next[29] = t3_reg[15] * b;
        t4_next[30] = t3_reg[16] * b;
        t4_next[31] = t3_reg[17] * g;
        t4_next[32] = t3_reg[17] * b;
        t4_next[33] = t3_reg[18] * b;
        t4_next[34] = t3_reg[19] * b;
        t4_next[35] = t3_reg[20] * b;
    end

    // stage 5: split partial products
    lo_t lo5_next [NUM_TERMS-1:0];
    hi_t hi5_next [NUM_TERMS-1:0];
    lo_t lo5_reg  [NUM_TERMS-1:0];
    hi_t hi5_reg  [NUM_TERMS-1:0];
    logic [8:0] band5_reg;
    logic v5_reg;

    always_comb begin
        for (int k = 0; k < NUM_TERMS; k++) begin
            lo5_next[k] = LO_W'(row4_reg[k][23:0]) * LO_W'(t4_reg[k]);
            hi5_next[k] = HI_W'($signed(row4_reg[k][47:24])) * HI_W'($signed({1'b0, t4_reg[k]}));
        end
    end

    // stage 6: full products
    prod_t p6_next [NUM_TERMS-1:0];
    prod_t p6_reg  [NUM_TERMS-1:0];
    logic [8:0] band6_reg;
    logic v6_reg;

    always_comb begin
        for (int k = 0; k < NUM_TERMS; k++) begin
            p6_next[k] = (PROD_W'(hi5_reg[k]) <<< FRAC_DROP)
                       + PROD_W'($signed({1'b0, lo5_reg[k]}));
        end
    end

    // stage 7: group sums
    sum_t s7_next [GROUPS-1:0];
    sum_t s7_reg  [GROUPS-1:0];
    logic [8:0] band7_reg;
    logic v7_reg;

    always_comb begin
        for (int j = 0; j < GROUPS; j++) begin
            s7_next[j] = '0;
            for (int i = 0; i < GROUP_N; i++) begin
                s7_next[j] = s7_next[j] + SUM_W'(p6_reg[j * GROUP_N + i]);
            end
        end
    end

    // stage 8: total
    sum_t s8_next, s8_reg;
    logic [8:0] band8_reg;
    logic v8_reg;

    always_comb begin
        s8_next = '0;
        for (int j = 0; j < GROUPS; j++) begin
            s8_next = s8_next + s7_reg[j];
        end
    end

    // stage 9: round and saturate
    sum_t rnd;
    logic signed [SUM_W-FRAC_DROP-1:0] q;
    logic sat_next;
    logic signed [31:0] val_next;

    always_comb begin
        rnd      = s8_reg + SUM_W'(64'd1 << (FRAC_DROP - 1));
        q        = rnd[SUM_W-1:FRAC_DROP];
        sat_next = !((&q[SUM_W-FRAC_DROP-1:31]) || !(|q[SUM_W-FRAC_DROP-1:31]));
        if (sat_next) begin
            val_next = q[SUM_W-FRAC_DROP-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            val_next = q[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t2_reg    <= t2_next;
            row2_reg  <= row1_reg;
            band2_reg <= band1_reg;
            r2_reg    <= r1_reg;
            g2_reg    <= g1_reg;
            b2_reg    <= b1_reg;
            t3_reg    <= t3_next;
            row3_reg  <= row2_reg;
            band3_reg <= band2_reg;
            r3_reg    <= r2_reg;
            g3_reg    <= g2_reg;
            b3_reg    <= b2_reg;
            t4_reg    <= t4_next;
            row4_reg  <= row3_reg;
            band4_reg <= band3_reg;
            lo5_reg   <= lo5_next;
            hi5_reg   <= hi5_next;
            band5_reg <= band4_reg;
            p6_reg    <= p6_next;
            band6_reg <= band5_reg;
            s7_reg    <= s7_next;
            band7_reg <= band6_reg;
            s8_reg    <= s8_next;
            band8_reg <= band7_reg;
            m_out_band       <= band8_reg;
            m_spectral_value <= val_next;
            m_saturated      <= sat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            m_valid <= 1'b0;
        end else if (adv) begin
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            m_valid <= v8_reg;
        end
    end

endmodule

// ===== tb/tb_rgb_polynomial_spectrum_eval.sv =====
`timescale 1ns / 1ps

module tb_rgb_polynomial_spectrum_eval;
    import rpse_pkg::*;

    localparam int BANDS = 512;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [8:0]         band;
        logic signed [31:0] value;
        logic               sat;
    } spec_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_cmd = CMD_WRITE;
    logic [7:0]         s_red = '0;
    logic [7:0]         s_green = '0;
    logic [7:0]         s_blue = '0;
    logic [8:0]         s_band = '0;
    logic [5:0]         s_term = '0;
    logic signed [47:0] s_coefficient = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [8:0]         m_out_band;
    logic signed [31:0] m_spectral_value;
    logic               m_saturated;

    coef_t  coef_mem [BANDS][NUM_TERMS];
    bit     coef_set [BANDS][NUM_TERMS];
    int     loaded_bands[$];
    spec_t  spectra_due[$];
    int     errors = 0;
    int     cycles = 0;
    bit     calm = 1'b0;

    always #5 aclk = ~aclk;

    rgb_polynomial_spectrum_eval dut (.*);

    function automatic spec_t predict_spectrum(logic [7:0] r, logic [7:0] g,
                                               logic [7:0] b, logic [8:0] band);
        logic [31:0]         v [3];
        logic [31:0]         mono [NUM_TERMS];
        logic signed [127:0] acc;
        logic signed [127:0] q;
        spec_t               res;
        int                  k;
        v[0] = 32'(r); v[1] = 32'(g); v[2] = 32'(b);
        mono[0] = 32'd1; mono[1] = 32'd1;
        k = 2;
        for (int i = 0; i < 3; i++) begin
            mono[k] = v[i]; k++;
        end
        for (int i = 0; i < 3; i++)
            for (int j = i; j < 3; j++) begin
                mono[k] = v[i] * v[j]; k++;
            end
        for (int i = 0; i < 3; i++)
            for (int j = i; j < 3; j++)
                for (int l = j; l < 3; l++) begin
                    mono[k] = v[i] * v[j] * v[l]; k++;
                end
        for (int i = 0; i < 3; i++)
            for (int j = i; j < 3; j++)
                for (int l = j; l < 3; l++)
                    for (int n = l; n < 3; n++) begin
                        mono[k] = v[i] * v[j] * v[l] * v[n]; k++;
                    end
        acc = '0;
        for (int t = 0; t < NUM_TERMS; t++)
            acc += 128'(coef_mem[band][t]) * $signed({96'b0, mono[t]});
        acc += 128'sd1 <<< 23;
        q = acc >>> 24;
        res.band = band;
        res.sat = 1'b0;
        if (q > 128'sd2147483647) begin
            res.sat = 1'b1;
            res.value = 32'sh7FFFFFFF;
        end else if (q < -128'sd2147483648) begin
            res.sat = 1'b1;
            res.value = 32'sh80000000;
        end else begin
            res.value = q[31:0];
        end
        return res;
    endfunction

    task automatic send_item(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic [8:0] band, logic [5:0] term, coef_t coef);
        bit full;
        if (!calm && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_red <= r;
        s_green <= g;
        s_blue <= b;
        s_band <= band;
        s_term <= term;
        s_coefficient <= coef;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (cmd == CMD_WRITE) begin
            if (term < NUM_TERMS) begin
                coef_mem[band][term] = coef;
                coef_set[band][term] = 1'b1;
                full = 1'b1;
                for (int t = 0; t < NUM_TERMS; t++) full &= coef_set[band][t];
                if (full && !(int'(band) inside {loaded_bands}))
                    loaded_bands.push_back(int'(band));
            end
        end else begin
            spectra_due.push_back(predict_spectrum(r, g, b, band));
        end
    endtask

    function automatic coef_t rand_coef();
        if ($urandom_range(2) == 0)
            return coef_t'({$urandom, $urandom});
        return coef_t'($signed(24'($urandom)));
    endfunction

    task automatic send_eval(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [8:0] band);
        send_item(CMD_EVAL, r, g, b, band, 6'($urandom), coef_t'({$urandom, $urandom}));
    endtask

    task automatic load_band(logic [8:0] band, int mode);
        coef_t c;
        for (int t = 0; t < NUM_TERMS; t++) begin
            case (mode)
                0: c = 48'sh7FFFFFFFFFFF;
                1: c = -48'sh800000000000;
                default: c = rand_coef();
            endcase
            send_item(CMD_WRITE, 8'($urandom), 8'($urandom), 8'($urandom), band,
                      6'(t), c);
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        spec_t e;
        if (aresetn && m_valid && m_ready) begin
            if (spectra_due.size() == 0) begin
                report_mismatch("unexpected transfer band", m_out_band, -1);
            end else begin
                e = spectra_due.pop_front();
                if (m_out_band !== e.band) report_mismatch("band", m_out_band, e.band);
                if (m_spectral_value !== e.value)
                    report_mismatch("value", m_spectral_value, e.value);
                if (m_saturated !== e.sat) report_mismatch("saturated", m_saturated, e.sat);
            end
        end
    end

    always @(posedge aclk)
        m_ready <= calm || ($urandom_range(99) >= 25);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_table_load();
        load_band(9'd0, 0);
        load_band(9'd511, 1);
        load_band(9'd170, 2);
        load_band(9'd341, 2);
    endtask

    task automatic test_corners();
        send_eval(8'd255, 8'd255, 8'd255, 9'd0);
        send_eval(8'd0, 8'd0, 8'd0, 9'd0);
        send_eval(8'd255, 8'd255, 8'd255, 9'd511);
        send_eval(8'd0, 8'd0, 8'd0, 9'd511);
        send_eval(8'd255, 8'd0, 8'd0, 9'd170);
        send_eval(8'd0, 8'd255, 8'd0, 9'd170);
        send_eval(8'd0, 8'd0, 8'd255, 9'd341);
        send_eval(8'd255, 8'd255, 8'd255, 9'd341);
        // out-of-range terms are dropped
        send_item(CMD_WRITE, 8'd0, 8'd0, 8'd0, 9'd170, 6'd36, 48'sh7FFFFFFFFFFF);
        send_item(CMD_WRITE, 8'd255, 8'd255, 8'd255, 9'd170, 6'd63, -48'sh800000000000);
        send_eval(8'd255, 8'd255, 8'd255, 9'd170);
        // rewrite then evaluate as the next item sent
        send_item(CMD_WRITE, 8'd0, 8'd0, 8'd0, 9'd170, 6'd35, 48'sh000001000000);
        send_eval(8'd128, 8'd64, 8'd1, 9'd170);
        send_item(CMD_WRITE, 8'd0, 8'd0, 8'd0, 9'd170, 6'd0, -48'sh000000000001);
        send_eval(8'd1, 8'd1, 8'd1, 9'd170);
    endtask

    task automatic test_random();
        int sel;
        int n = 0;
        while (n < 500) begin
            calm = (n >= 200 && n < 300);
            sel = $urandom_range(99);
            if (sel < 8 && loaded_bands.size() < 40) begin
                load_band(9'($urandom), 2);
                n += 36;
            end else if (sel < 30) begin
                send_item(CMD_WRITE, 8'($urandom), 8'($urandom), 8'($urandom),
                          9'(loaded_bands[$urandom_range(loaded_bands.size() - 1)]),
                          6'($urandom_range(sel < 27 ? 35 : 63)), rand_coef());
                n++;
            end else begin
                send_eval(8'($urandom), 8'($urandom), 8'($urandom),
                          9'(loaded_bands[$urandom_range(loaded_bands.size() - 1)]));
                n++;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_table_load();
        test_corners();
        test_random();
        s_valid <= 1'b0;
        while (spectra_due.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rpse_pkg.sv
rtl/rgb_polynomial_spectrum_eval.sv
tb/tb_rgb_polynomial_spectrum_eval.sv
